// ----- src/pidic_pkg.sv -----
package pidic_pkg;

	localparam int ERR_W   = 25;
	localparam int GAIN_W  = 32;
	localparam int DRIVE_W = 32;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// register indexes, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_INTEGRAL_MAX = 3'd3,
		REG_INTEGRAL_MIN = 3'd4
	} pidic_reg_t;

	// input op codes
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// register reset values
	localparam logic signed [GAIN_W-1:0] GAIN_P_RST       = 32'sd1677722;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST       = 32'sd16777;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST       = 32'sd0;
	localparam logic signed [ERR_W-1:0]  INTEGRAL_MAX_RST = 25'sd16776960;
	localparam logic signed [ERR_W-1:0]  INTEGRAL_MIN_RST = -25'sd16776960;

	// controller settings as seen by the datapath
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic signed [ERR_W-1:0]  integral_max;
		logic signed [ERR_W-1:0]  integral_min;
	} pidic_cfg_t;

endpackage

// ----- src/pid_controller_integrator_clamp.sv -----
// PID controller with a clamped integrator in fixed point. Error samples are
// signed Q17.8, gains signed Q8.24, drive signed Q24.8 saturated to 32 bits.
// One word is accepted every clock cycle while the output is taken. The input
// register loads at the accepting edge; each result then passes the product,
// integrator and output registers. The integrator add and clamp close within
// one stage, so throughput stays at one word per cycle. Gains and clamp limits
// sit on the APB port at byte addresses 0x00 to 0x10; the user must write them
// only while the block is idle, which the block itself does not enforce.
module pid_controller_integrator_clamp
	import pidic_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [ERR_W-1:0]   error_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] drive
);

	pidic_cfg_t cfg;

	// configuration registers
	pidic_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// controller pipeline
	pidic_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.error_in  (error_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

endmodule

// ----- src/pidic_regs.sv -----
module pidic_regs
	import pidic_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output pidic_cfg_t        cfg
);

	logic       wr_en;
	logic [2:0] idx;
	pidic_cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= GAIN_P_RST;
			cfg_q.gain_i       <= GAIN_I_RST;
			cfg_q.gain_d       <= GAIN_D_RST;
			cfg_q.integral_max <= INTEGRAL_MAX_RST;
			cfg_q.integral_min <= INTEGRAL_MIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_P:       cfg_q.gain_p       <= pwdata;
				REG_GAIN_I:       cfg_q.gain_i       <= pwdata;
				REG_GAIN_D:       cfg_q.gain_d       <= pwdata;
				REG_INTEGRAL_MAX: cfg_q.integral_max <= pwdata[ERR_W-1:0];
				REG_INTEGRAL_MIN: cfg_q.integral_min <= pwdata[ERR_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux, clamp limits sign-extended
	always_comb begin
		unique case (idx)
			REG_GAIN_P:       prdata = cfg_q.gain_p;
			REG_GAIN_I:       prdata = cfg_q.gain_i;
			REG_GAIN_D:       prdata = cfg_q.gain_d;
			REG_INTEGRAL_MAX: prdata = {{(DATA_W-ERR_W){cfg_q.integral_max[ERR_W-1]}},
				cfg_q.integral_max};
			REG_INTEGRAL_MIN: prdata = {{(DATA_W-ERR_W){cfg_q.integral_min[ERR_W-1]}},
				cfg_q.integral_min};
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- src/pidic_datapath.sv -----
module pidic_datapath
	import pidic_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  pidic_cfg_t                cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [ERR_W-1:0]   error_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] drive
);

	// stage readiness
	logic rdy_out, rdy3, rdy2;
	logic load_in;

	// control state
	logic                    v1_s1, v2_s2, v3_s3, out_valid_q;
	logic signed [ERR_W-1:0] last_err_q;
	logic                    started_q;
	logic signed [ERR_W-1:0] integral_q;

	// stage 1: input word
	logic                    op_s1, first_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic signed [ERR_W:0]   diff_s1;

	// stage 2: scaled products
	logic                    op_s2, first_s2;
	logic signed [32:0]      p_s2;
	logic signed [32:0]      inc_s2;
	logic signed [33:0]      d_s2;

	// stage 3: integrator and p + d
	logic signed [ERR_W-1:0] int_s3;
	logic signed [34:0]      pd_s3;

	logic signed [DRIVE_W-1:0] drive_q;

	logic signed [ERR_W:0]   diff_in;
	logic signed [56:0]      prod_p, prod_i;
	logic signed [57:0]      prod_d;
	logic signed [33:0]      acc, acc_hi, acc_lim, max_x, min_x;
	logic signed [ERR_W-1:0] int_new;
	logic signed [34:0]      pd_sum;
	logic signed [35:0]      total;
	logic signed [DRIVE_W-1:0] sat;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy3     = !v3_s3 || rdy_out;
	assign rdy2     = !v2_s2 || rdy3;
	assign in_ready = !v1_s1 || rdy2;
	assign load_in  = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// valid bits and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
			last_err_q  <= '0;
			started_q   <= 1'b0;
			integral_q  <= '0;
		end else begin
			if (in_ready) v1_s1 <= in_valid;
			if (rdy2)     v2_s2 <= v1_s1;
			if (rdy3)     v3_s3 <= v2_s2;
			if (rdy_out)  out_valid_q <= v3_s3;
			if (load_in) begin
				last_err_q <= (op == OP_CLEAR) ? '0 : error_in;
				started_q  <= (op == OP_STEP);
			end
			if (rdy3 && v2_s2) integral_q <= (op_s2 == OP_CLEAR) ? '0 : int_new;
		end
	end

	// error difference against the previous sample
	assign diff_in = {error_in[ERR_W-1], error_in} - {last_err_q[ERR_W-1], last_err_q};

	always_ff @(posedge clk) begin
		if (load_in) begin
			op_s1    <= op;
			err_s1   <= error_in;
			diff_s1  <= diff_in;
			first_s1 <= !started_q;
		end
	end

	// gain products, floor of product / 2^24
	assign prod_p = cfg.gain_p * err_s1;
	assign prod_i = cfg.gain_i * err_s1;
	assign prod_d = cfg.gain_d * diff_s1;

	always_ff @(posedge clk) begin
		if (rdy2 && v1_s1) begin
			op_s2    <= op_s1;
			first_s2 <= first_s1;
			p_s2     <= prod_p[56:24];
			inc_s2   <= prod_i[56:24];
			d_s2     <= prod_d[57:24];
		end
	end

	// integrator add, upper clamp then lower clamp
	always_comb begin
		max_x   = {{(34-ERR_W){cfg.integral_max[ERR_W-1]}}, cfg.integral_max};
		min_x   = {{(34-ERR_W){cfg.integral_min[ERR_W-1]}}, cfg.integral_min};
		acc     = {{(34-ERR_W){integral_q[ERR_W-1]}}, integral_q} + {inc_s2[32], inc_s2};
		acc_hi  = (acc > max_x) ? max_x : acc;
		acc_lim = (acc_hi < min_x) ? min_x : acc_hi;
		int_new = (cfg.gain_i != '0) ? acc_lim[ERR_W-1:0] : integral_q;
		pd_sum  = {{2{p_s2[32]}}, p_s2} + (first_s2 ? 35'sd0 : {d_s2[33], d_s2});
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			int_s3 <= (op_s2 == OP_CLEAR) ? '0 : int_new;
			pd_s3  <= (op_s2 == OP_CLEAR) ? '0 : pd_sum;
		end
	end

	// final sum and saturation to 32 bits
	always_comb begin
		total = {pd_s3[34], pd_s3} + {{(36-ERR_W){int_s3[ERR_W-1]}}, int_s3};
		if (total[35:DRIVE_W-1] == '0 || total[35:DRIVE_W-1] == '1)
			sat = total[DRIVE_W-1:0];
		else if (total[35])
			sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		else
			sat = {1'b0, {(DRIVE_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v3_s3) drive_q <= sat;
	end

	// integrator never ends below the lower limit after an update
	a_int_min: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy3 && v2_s2 && op_s2 == OP_STEP && cfg.gain_i != '0)
		|=> (integral_q >= $past(cfg.integral_min)))
		else $error("integrator below lower limit");

	// a clear leaving stage 2 empties the integrator
	a_clear_int: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy3 && v2_s2 && op_s2 == OP_CLEAR) |=> (integral_q == '0))
		else $error("integrator not cleared");

	// an empty output stage never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output");

endmodule

// ----- test/pid_controller_integrator_clamp_tb.sv -----
module pid_controller_integrator_clamp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pidic_pkg::*;

	localparam int     LATENCY    = 4;
	localparam int     IDLE_LIMIT = 2000;
	localparam int     RAND_WORDS = 75;
	localparam int     RAND_SETS  = 10;
	localparam longint DRIVE_HI   = 64'sd2147483647;
	localparam longint DRIVE_LO   = -64'sd2147483648;

	typedef struct {
		logic                    op;
		logic signed [ERR_W-1:0] err;
	} pid_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_W-1:0]         paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic                      op;
	logic signed [ERR_W-1:0]   error_in;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DRIVE_W-1:0] drive;

	// words waiting to be sent and drive values waiting to come back
	pid_word_t                 word_q[$];
	logic signed [DRIVE_W-1:0] drive_q[$];
	logic signed [DRIVE_W-1:0] want_drive;

	// controller settings and state as the checker sees them
	longint cfg_gain_p, cfg_gain_i, cfg_gain_d, cfg_int_max, cfg_int_min;
	longint acc_integral, prev_error;
	bit     primed;

	int in_issue_cnt, in_accept_cnt, out_seen_cnt, out_accept_cnt;
	int in_gap, out_gap, idle_cycles, err_cnt;
	int words_seen, clears_seen, settings_cnt;
	bit in_idle_on, out_idle_on;

	pid_controller_integrator_clamp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.error_in  (error_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// one pid step on an accepted word, returns the drive it must produce
	function automatic logic signed [DRIVE_W-1:0] pid_next_drive(input logic op_w,
			input logic signed [ERR_W-1:0] err);
		longint e, p, d, acc, sum;
		if (op_w == OP_CLEAR) begin
			acc_integral = 0;
			prev_error   = 0;
			primed       = 1'b0;
			return '0;
		end
		e = err;
		p = (cfg_gain_p * e) >>> 24;
		// integrator moves and clamps only with a nonzero gain, upper limit first
		if (cfg_gain_i != 0) begin
			acc = acc_integral + ((cfg_gain_i * e) >>> 24);
			if (acc > cfg_int_max)
				acc = cfg_int_max;
			if (acc < cfg_int_min)
				acc = cfg_int_min;
			acc_integral = acc;
		end
		d = (cfg_gain_d * (e - prev_error)) >>> 24;
		prev_error = e;
		// no derivative on the first step after clear
		if (!primed) begin
			primed = 1'b1;
			sum = p + acc_integral;
		end else begin
			sum = p + acc_integral + d;
		end
		if (sum > DRIVE_HI)
			sum = DRIVE_HI;
		if (sum < DRIVE_LO)
			sum = DRIVE_LO;
		return DRIVE_W'(sum);
	endfunction

	function automatic int draw_gap(input bit on);
		return on ? int'($urandom_range(0, 13)) : 0;
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom();
			default: return DATA_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
	endfunction

	function automatic logic signed [ERR_W-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 25'sh0FF_FFFF;
			1: return 25'sh100_0000;
			2: return ERR_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
			default: return ERR_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [ERR_W-1:0] pick_error();
		case ($urandom_range(0, 9))
			0: return 25'sh0FF_FFFF;
			1: return 25'sh100_0000;
			2: return ERR_W'(int'($urandom_range(0, 1024)) - 512);
			3: return '0;
			default: return ERR_W'($urandom());
		endcase
	endfunction

	task automatic push_word(input logic op_w, input logic signed [ERR_W-1:0] err);
		pid_word_t w;
		w.op  = op_w;
		w.err = err;
		word_q.push_back(w);
	endtask

	// apb write: setup cycle, access cycle, then release
	task automatic reg_write(input pidic_reg_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GAIN_P:       cfg_gain_p  = longint'($signed(value));
			REG_GAIN_I:       cfg_gain_i  = longint'($signed(value));
			REG_GAIN_D:       cfg_gain_d  = longint'($signed(value));
			REG_INTEGRAL_MAX: cfg_int_max = longint'($signed(value[ERR_W-1:0]));
			REG_INTEGRAL_MIN: cfg_int_min = longint'($signed(value[ERR_W-1:0]));
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
			input logic [DATA_W-1:0] gd, input logic signed [ERR_W-1:0] hi,
			input logic signed [ERR_W-1:0] lo);
		reg_write(REG_GAIN_P, gp);
		reg_write(REG_GAIN_I, gi);
		reg_write(REG_GAIN_D, gd);
		reg_write(REG_INTEGRAL_MAX, DATA_W'(hi));
		reg_write(REG_INTEGRAL_MIN, DATA_W'(lo));
		settings_cnt++;
	endtask

	// hold off until every word is sent and every drive value is back
	task automatic drain();
		do
			@(posedge clk);
		while (word_q.size() != 0 || in_accept_cnt != in_issue_cnt || drive_q.size() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// word driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_accept_cnt == in_issue_cnt) begin
				if (in_valid)
					in_gap = draw_gap(in_idle_on);
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (word_q.size() != 0) begin
					op       <= word_q[0].op;
					error_in <= word_q[0].err;
					in_valid <= 1'b1;
					void'(word_q.pop_front());
					in_issue_cnt++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_seen_cnt != out_accept_cnt) begin
				out_seen_cnt = out_accept_cnt;
				out_gap      = draw_gap(out_idle_on);
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check drive words, predict for accepted input words
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				out_accept_cnt++;
				if (drive_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected drive word, expected none, got %0d", $time, drive);
				end else begin
					want_drive = drive_q.pop_front();
					if (drive !== want_drive) begin
						err_cnt++;
						$display("%0t: drive mismatch, expected %0d, got %0d", $time,
							want_drive, drive);
					end
				end
			end
			if (in_valid && in_ready) begin
				in_accept_cnt++;
				words_seen++;
				if (op == OP_CLEAR)
					clears_seen++;
				drive_q.push_back(pid_next_drive(op, error_in));
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// watchdog on handshake activity
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic signed [ERR_W-1:0] hi, lo, tmp;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		op        = OP_STEP;
		error_in  = '0;
		out_ready = 1'b0;
		cfg_gain_p  = GAIN_P_RST;
		cfg_gain_i  = GAIN_I_RST;
		cfg_gain_d  = GAIN_D_RST;
		cfg_int_max = INTEGRAL_MAX_RST;
		cfg_int_min = INTEGRAL_MIN_RST;
		acc_integral = 0;
		prev_error   = 0;
		primed       = 1'b0;
		in_idle_on   = 1'b1;
		out_idle_on  = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_cnt = 1;

		// reset settings: field extremes, clear, first step without derivative
		@(posedge clk);
		push_word(OP_CLEAR, 25'sh0AB_CDEF);
		push_word(OP_STEP, 25'sh0FF_FFFF);
		push_word(OP_STEP, 25'sh100_0000);
		push_word(OP_STEP, '0);
		push_word(OP_STEP, 25'sd1);
		push_word(OP_STEP, -25'sd1);
		push_word(OP_CLEAR, '0);
		push_word(OP_STEP, 25'sd5);
		drain();

		// extreme gains: output saturates both ways, integrator pinned at limits
		write_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 25'sh0FF_FFFF,
			25'sh100_0000);
		@(posedge clk);
		push_word(OP_STEP, 25'sh0FF_FFFF);
		push_word(OP_STEP, 25'sh100_0000);
		push_word(OP_STEP, 25'sh0FF_FFFF);
		push_word(OP_CLEAR, 25'sh1FF_FFFF);
		push_word(OP_STEP, 25'sh100_0000);
		push_word(OP_STEP, 25'sh0FF_FFFF);
		drain();

		// zero integral gain freezes the integrator, with limits crossed
		write_settings(32'h0100_0000, '0, 32'h8000_0000, -25'sd1000, 25'sd1000);
		@(posedge clk);
		push_word(OP_STEP, 25'sd4000);
		push_word(OP_STEP, -25'sd4000);
		push_word(OP_STEP, 25'sd7);
		drain();

		// crossed limits with a live integrator always land on the minimum
		reg_write(REG_GAIN_I, 32'h0100_0000);
		@(posedge clk);
		push_word(OP_STEP, 25'sd50000);
		push_word(OP_STEP, -25'sd50000);
		push_word(OP_STEP, 25'sd3);
		drain();

		// random settings, random words; each set ends with a full drain
		for (int s = 0; s < RAND_SETS; s++) begin
			hi = pick_limit();
			lo = pick_limit();
			if ($urandom_range(0, 4) != 0 && lo > hi) begin
				tmp = hi;
				hi  = lo;
				lo  = tmp;
			end
			write_settings(pick_gain(), pick_gain(), pick_gain(), hi, lo);
			in_idle_on  = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			@(posedge clk);
			for (int n = 0; n < RAND_WORDS; n++) begin
				if ($urandom_range(0, 11) == 0)
					push_word(OP_CLEAR, ERR_W'($urandom()));
				else
					push_word(OP_STEP, pick_error());
			end
			drain();
		end

		if (drive_q.size() != 0) begin
			err_cnt += drive_q.size();
			$display("%0t: %0d drive words never arrived", $time, drive_q.size());
		end
		$display("run covered %0d words (%0d clears) under %0d register settings",
			words_seen, clears_seen, settings_cnt);
		$display("with gain extremes, zero integral gain, crossed limits and random stalls");
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
